// ----- rtl/cmaa_pkg.sv -----
// Shared constants for the calibrated moving-average anomaly detector.
// Holds the field widths, register reset values and register index codes.
// No dependencies.
package cmaa_pkg;

  localparam int DATA_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DEFAULT_WINDOW_DEPTH = 10;

  localparam logic [DATA_W-1:0] GAIN_RESET      = 16'd16712;
  localparam logic [DATA_W-1:0] OFFSET_RESET    = 16'hFFB3;
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 16'd1280;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

endpackage

// ----- rtl/calibrated_moving_average_anomaly.sv -----
// Calibrated moving-average anomaly detector, top level.
// Depends on cmaa_pkg for widths, reset values and register index codes.
//
// Each raw Q8.8 sample is calibrated (gain times raw plus offset, rounded and
// saturated), compared against the mean of the previously stored samples, and
// then pushed into a ring of WINDOW_DEPTH entries. The block works on one
// sample at a time: each passes through the multiply, calibrate, divide and
// finish states, and the divide state is skipped while the ring is still
// empty. The result register is loaded on leaving the finish state, and the
// next sample is accepted once the block is back in idle. The restoring
// divider produces one quotient bit per cycle over the width of the running
// sum (SUM_W bits, 20 at the default depth of 10). A result waits in the
// output register until it is taken; a finished sample holds until the
// previous result has left.
module calibrated_moving_average_anomaly #(
  parameter int WINDOW_DEPTH = cmaa_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cmaa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cmaa_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cmaa_pkg::DATA_W-1:0]  in_raw_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cmaa_pkg::DATA_W-1:0]  out_cal_sample,
  output logic signed [cmaa_pkg::DATA_W-1:0]  out_window_average,
  output logic                                out_anomaly_flag
);
  import cmaa_pkg::*;

  localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = DATA_W + $clog2(WINDOW_DEPTH);
  localparam int ITER_W = $clog2(SUM_W);
  localparam int PROD_W = 2 * DATA_W + 1;

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_DEPTH);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CAL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Configuration registers
  logic [DATA_W-1:0]        gain_r;
  logic signed [DATA_W-1:0] offset_r;
  logic [DATA_W-1:0]        threshold_r;

  // Window state
  logic signed [DATA_W-1:0] store_mem [WINDOW_DEPTH];
  logic [POS_W-1:0]         pos_r;
  logic                     full_r;
  logic signed [SUM_W-1:0]  sum_r;

  // Sequencer and datapath
  logic [2:0]               state_r, state_nxt;
  logic signed [DATA_W-1:0] raw_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DATA_W-1:0] old_r;
  logic signed [DATA_W-1:0] cal_r;
  logic [CNT_W-1:0]         count_r;
  logic [SUM_W-1:0]         quo_r;
  logic [CNT_W-1:0]         rem_r;
  logic                     neg_r;
  logic [ITER_W-1:0]        iter_r;

  // Result register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_cal_r;
  logic signed [DATA_W-1:0] out_avg_r;
  logic                     out_flag_r;

  // Combinational helpers
  logic [CNT_W-1:0]         count_now;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-15:0] shf;
  logic signed [PROD_W-14:0] cal_wide;
  logic signed [DATA_W-1:0] cal_sat;
  logic [SUM_W-1:0]         sum_abs;
  logic [CNT_W:0]           rem_sh;
  logic                     q_bit;
  logic [CNT_W-1:0]         rem_nxt;
  logic [SUM_W-1:0]         quo_signed;
  logic signed [DATA_W-1:0] mean;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          diff_abs;
  logic                     flag;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic                     slot_free;
  logic                     finish;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_cal_sample     = out_cal_r;
  assign out_window_average = out_avg_r;
  assign out_anomaly_flag   = out_flag_r;

  assign count_now = full_r ? CNT_FULL : CNT_W'(pos_r);

  // Round the Q10.22 product to Q8.8 (halves toward +infinity), add offset.
  // The product magnitude stays below 2^31, so the rounding add cannot overflow.
  assign rnd      = prod_r + PROD_W'(8192);
  assign shf      = rnd[PROD_W-1:14];
  assign cal_wide = {shf[PROD_W-15], shf} + (PROD_W-13)'(offset_r);

  always_comb begin
    if (cal_wide > (PROD_W-13)'(32767)) begin
      cal_sat = 16'sh7FFF;
    end else if (cal_wide < -(PROD_W-13)'(32768)) begin
      cal_sat = -16'sh8000;
    end else begin
      cal_sat = cal_wide[DATA_W-1:0];
    end
  end

  assign sum_abs = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  // One restoring-division step per cycle.
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, count_r});
  assign rem_nxt = q_bit ? CNT_W'(rem_sh - {1'b0, count_r}) : rem_sh[CNT_W-1:0];

  // The quotient magnitude is at most 32768, so the low bits carry the mean.
  assign quo_signed = neg_r ? SUM_W'(-quo_r) : quo_r;
  assign mean       = quo_signed[DATA_W-1:0];

  assign diff     = {cal_r[DATA_W-1], cal_r} - {mean[DATA_W-1], mean};
  assign diff_abs = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
  assign flag     = full_r && (diff_abs > {1'b0, threshold_r});

  assign sum_nxt = sum_r + SUM_W'(cal_r) - (full_r ? SUM_W'(old_r) : SUM_W'(0));

  assign slot_free = !out_valid_r || out_ready;
  assign finish    = (state_r == S_FIN) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_CAL;
      S_CAL: state_nxt = (count_r == '0) ? S_FIN : S_DIV;
      S_DIV: begin
        if (iter_r == '0) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      offset_r    <= OFFSET_RESET;
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:      gain_r      <= cfg_data;
        REG_OFFSET:    offset_r    <= cfg_data;
        REG_THRESHOLD: threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish || (out_valid_r && !out_ready);
      if (finish) begin
        sum_r <= sum_nxt;
        if (pos_r == POS_LAST) begin
          pos_r  <= '0;
          full_r <= 1'b1;
        end else begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
    end
  end

  // Datapath registers; none of these need a reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_r <= in_raw_sample;
    end
    if (state_r == S_MUL) begin
      prod_r  <= PROD_W'($signed({1'b0, gain_r})) * PROD_W'(raw_r);
      old_r   <= store_mem[pos_r];
      count_r <= count_now;
    end
    if (state_r == S_CAL) begin
      cal_r  <= cal_sat;
      rem_r  <= '0;
      iter_r <= ITER_LAST;
      if (count_r == '0) begin
        quo_r <= '0;
        neg_r <= 1'b0;
      end else begin
        quo_r <= sum_abs;
        neg_r <= sum_r[SUM_W-1];
      end
    end
    if (state_r == S_DIV) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[SUM_W-2:0], q_bit};
      iter_r <= iter_r - ITER_W'(1);
    end
    if (finish) begin
      store_mem[pos_r] <= cal_r;
      out_cal_r        <= cal_r;
      out_avg_r        <= mean;
      out_flag_r       <= flag;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for calibrated_moving_average_anomaly.
// Depends on cmaa_pkg and the detector RTL; predicts every result in place.
module tb_top;
  import cmaa_pkg::*;

  localparam int DEPTH = DEFAULT_WINDOW_DEPTH;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 165;

  typedef struct packed {
    logic signed [DATA_W-1:0] calibrated;
    logic signed [DATA_W-1:0] average;
    logic                     anomaly;
  } detection_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GAIN;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] in_raw_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_cal_sample;
  logic signed [DATA_W-1:0] out_window_average;
  logic out_anomaly_flag;

  calibrated_moving_average_anomaly #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_raw_sample(in_raw_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cal_sample(out_cal_sample),
    .out_window_average(out_window_average),
    .out_anomaly_flag(out_anomaly_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Detector state as the predictor sees it.
  logic [DATA_W-1:0]        cur_gain = GAIN_RESET;
  logic signed [DATA_W-1:0] cur_offset = OFFSET_RESET;
  logic [DATA_W-1:0]        cur_thresh = THRESHOLD_RESET;
  logic signed [DATA_W-1:0] ring [DEPTH];
  int ring_pos = 0;
  bit ring_full = 1'b0;
  int ring_sum = 0;

  logic signed [DATA_W-1:0] raw_backlog [$];
  detection_t pending_results [$];
  int fail_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic drv_next;

  function automatic detection_t predict_detection(logic signed [DATA_W-1:0] raw);
    longint scaled;
    int cal;
    int count;
    int mean;
    int diff;
    detection_t d;
    // Round the Q10.22 product to Q8.8 with halves going up, then add the offset.
    scaled = (longint'(cur_gain) * longint'(raw) + 64'sd8192) >>> 14;
    scaled = scaled + longint'(cur_offset);
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    cal = int'(scaled);
    count = ring_full ? DEPTH : ring_pos;
    mean = (count != 0) ? ring_sum / count : 0;
    diff = cal - mean;
    if (diff < 0) diff = -diff;
    d.calibrated = cal[DATA_W-1:0];
    d.average = mean[DATA_W-1:0];
    d.anomaly = ring_full && (diff > int'(cur_thresh));
    if (ring_full) ring_sum -= int'(ring[ring_pos]);
    ring[ring_pos] = cal[DATA_W-1:0];
    ring_sum += cal;
    ring_pos++;
    if (ring_pos == DEPTH) begin
      ring_pos = 0;
      ring_full = 1'b1;
    end
    return d;
  endfunction

  // Sample driver: the head of the backlog stays on the bus until its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drv_next = in_valid;
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_detection(in_raw_sample));
        void'(raw_backlog.pop_front());
        drv_next = 1'b0;
      end
      if (!drv_next && raw_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        drv_next = 1'b1;
        in_raw_sample <= raw_backlog[0];
      end
      in_valid <= drv_next;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no sample outstanding");
          fail_count++;
        end else begin
          detection_t exp_res;
          exp_res = pending_results.pop_front();
          if (out_cal_sample !== exp_res.calibrated) begin
            $error("cal_sample: expected %0d, got %0d",
                   exp_res.calibrated, out_cal_sample);
            fail_count++;
          end
          if (out_window_average !== exp_res.average) begin
            $error("window_average: expected %0d, got %0d",
                   exp_res.average, out_window_average);
            fail_count++;
          end
          if (out_anomaly_flag !== exp_res.anomaly) begin
            $error("anomaly_flag: expected %0d, got %0d",
                   exp_res.anomaly, out_anomaly_flag);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_GAIN:      cur_gain = value;
      REG_OFFSET:    cur_offset = value;
      REG_THRESHOLD: cur_thresh = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_calibration(logic [DATA_W-1:0] g, logic [DATA_W-1:0] o,
                                 logic [DATA_W-1:0] t);
    write_reg(REG_GAIN, g);
    write_reg(REG_OFFSET, o);
    write_reg(REG_THRESHOLD, t);
  endtask

  task automatic wait_drained();
    while (raw_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic signed [DATA_W-1:0] first_fill [14];
    int level;
    int sample;
    int mode;
    first_fill = '{16'sd0, 16'sd1, -16'sd1, 16'sd1024, -16'sd1024, 16'sd32767,
                   -16'sd32768, 16'sd32767, -16'sd32768, -16'sd3, 16'sd32767,
                   16'sd0, -16'sd32768, 16'sd100};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset calibration: the partly filled ring, rounding
    // halves at plus and minus 1024, and the extremes once the ring is full.
    foreach (first_fill[i]) raw_backlog.push_back(first_fill[i]);
    wait_drained();

    // Zero gain and the lowest offset pin every sample at the negative rail.
    set_calibration(16'd0, 16'h8000, 16'd0);
    write_reg(REG_SPARE, 16'hFFFF);
    raw_backlog.push_back(16'sd0);
    raw_backlog.push_back(16'sd5);
    wait_drained();

    // Top gain and offset saturate high, -32768 low; top threshold never trips.
    set_calibration(16'hFFFF, 16'h7FFF, 16'hFFFF);
    raw_backlog.push_back(16'sd32767);
    raw_backlog.push_back(-16'sd32768);
    raw_backlog.push_back(16'sd12345);
    wait_drained();

    level = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_calibration(GAIN_RESET, OFFSET_RESET, THRESHOLD_RESET);
        3: set_calibration(16'hFFFF, 16'h8000, 16'd0);
        5: set_calibration(16'd16384, 16'd0, 16'hFFFF);
        default: set_calibration(16'($urandom_range(8192, 40000)),
                                 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 3000)));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      // Mostly a slowly moving level with small noise, so the mean settles and
      // spikes stand out; the rest are spikes and fully random samples.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 49) == 0) level = $urandom_range(0, 40000) - 20000;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
          sample = $signed(16'($urandom));
        end else if (mode == 2) begin
          sample = level + ($urandom_range(0, 1) ? 4000 : -4000)
                   + $urandom_range(0, 8000) - 4000;
        end else begin
          sample = level + $urandom_range(0, 600) - 300;
        end
        if (sample > 32767) sample = 32767;
        if (sample < -32768) sample = -32768;
        raw_backlog.push_back(sample[DATA_W-1:0]);
      end
      wait_drained();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
